[hw/rtl/lwbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lwbc_pkg;

    // Fixed field widths of the request and response words.
    localparam int OpW      = 2;
    localparam int PageW    = 32;
    localparam int SlotOutW = 4;
    localparam int OccW     = 5;
    localparam int CapW     = 5;

    // Register port: one 32-bit register, selected by address bit RegIdxBit.
    localparam int AddrW     = 3;
    localparam int DataW     = 32;
    localparam int RegIdxBit = 2;
    localparam logic REG_CAP_LIMIT = 1'b0;

    typedef enum logic [OpW-1:0] {
        OP_GET   = 2'd0,
        OP_MARK  = 2'd1,
        OP_FLUSH = 2'd2
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch request and lookup results
        logic apply;     // update state for get / mark / unknown op, load response
        logic fl_emit;   // emit a flush writeback for the current slot
        logic fl_adv;    // step the flush pointer
        logic fl_last;   // emit the closing flush word
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // response register can take a word this cycle
        logic fl_hit;    // current flush slot is valid and dirty
        logic fl_end;    // flush pointer sits on the last slot
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/lwbc_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lwbc_req_if;
    import lwbc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OpW-1:0]   op;
    logic [PageW-1:0] page_id;

    modport source (output valid, output op, output page_id, input ready);
    modport sink   (input valid, input op, input page_id, output ready);
endinterface

`default_nettype wire

[hw/rtl/lwbc_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lwbc_rsp_if;
    import lwbc_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [SlotOutW-1:0] slot;
    logic                fetch;
    logic                writeback;
    logic [PageW-1:0]    writeback_page;
    logic                last;
    logic [OccW-1:0]     occupancy;

    modport source (output valid, output hit, output slot, output fetch, output writeback,
                    output writeback_page, output last, output occupancy, input ready);
    modport sink   (input valid, input hit, input slot, input fetch, input writeback,
                    input writeback_page, input last, input occupancy, output ready);
endinterface

`default_nettype wire

[hw/rtl/lru_write_back_page_cache.sv]
`timescale 1ns / 1ps
`default_nettype none

// Fully associative page-tag cache with least-recently-used replacement and dirty marks.
// Requests arrive on i_req (op, page_id) and response words leave on o_rsp, both with a
// valid/ready handshake. Get and mark-dirty give one word each; flush gives one writeback
// word per dirty slot in ascending slot order and then a closing word with last set.
// An unknown op also gives one word. When a get, mark-dirty or unknown op is accepted,
// the tag compare results are registered at acceptance, and the state update happens in
// the APPLY state once the response register is free, which also loads the response
// register. The response is visible the cycle after that, and the next request can be
// taken then. A flush walks the slots one per cycle unless a dirty slot waits for the
// response register, then emits the closing word before the next request is taken.
// The response register is the only output buffer: while it holds an untaken word the
// block accepts a new request but waits before loading the next word, so a stalled
// receiver holds the update or flush step, and nothing is lost or repeated.
// Reset clears valid and dirty bits, recency ranks, the resident count and the capacity
// register at once; tags need no clearing, there is no clearing pass. The request channel
// is not ready while reset is held.
// The capacity_limit register sits at byte address 0 of the register port. The user must
// write it only while the block is idle; the block itself does not enforce this.
module lru_write_back_page_cache #(
    parameter int SLOTS        = 16,
    parameter int PAGE_ID_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lwbc_req_if.sink                         i_req,
    lwbc_rsp_if.source                       o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lwbc_pkg::AddrW-1:0]  paddr,
    input  wire logic [lwbc_pkg::DataW-1:0]  pwdata,
    output logic      [lwbc_pkg::DataW-1:0]  prdata,
    output logic                             pready
);
    import lwbc_pkg::*;

    logic [CapW-1:0] r_cap_limit;
    t_ctl_cmd        cmd;
    t_dp_stat        stat;
    logic            cfg_wr;

    // Register port: no wait states, written on the access phase of a write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[RegIdxBit] == REG_CAP_LIMIT) ? DataW'(r_cap_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_limit <= '0;
        end else if (cfg_wr && paddr[RegIdxBit] == REG_CAP_LIMIT) begin
            r_cap_limit <= pwdata[CapW-1:0];
        end
    end

    lwbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    lwbc_dp #(
        .SLOTS        (SLOTS),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_cap_limit          (r_cap_limit),
        .i_req_op             (i_req.op),
        .i_req_page_id        (i_req.page_id),
        .i_rsp_ready          (o_rsp.ready),
        .o_rsp_valid          (o_rsp.valid),
        .o_rsp_hit            (o_rsp.hit),
        .o_rsp_slot           (o_rsp.slot),
        .o_rsp_fetch          (o_rsp.fetch),
        .o_rsp_writeback      (o_rsp.writeback),
        .o_rsp_writeback_page (o_rsp.writeback_page),
        .o_rsp_last           (o_rsp.last),
        .o_rsp_occupancy      (o_rsp.occupancy)
    );

endmodule

`default_nettype wire

[hw/rtl/lwbc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module lwbc_dp #(
    parameter int SLOTS        = 16,
    parameter int PAGE_ID_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lwbc_pkg::t_ctl_cmd            i_cmd,
    output lwbc_pkg::t_dp_stat                 o_stat,
    input  wire logic [lwbc_pkg::CapW-1:0]     i_cap_limit,
    input  wire logic [lwbc_pkg::OpW-1:0]      i_req_op,
    input  wire logic [lwbc_pkg::PageW-1:0]    i_req_page_id,
    input  wire logic                          i_rsp_ready,
    output logic                               o_rsp_valid,
    output logic                               o_rsp_hit,
    output logic [lwbc_pkg::SlotOutW-1:0]      o_rsp_slot,
    output logic                               o_rsp_fetch,
    output logic                               o_rsp_writeback,
    output logic [lwbc_pkg::PageW-1:0]         o_rsp_writeback_page,
    output logic                               o_rsp_last,
    output logic [lwbc_pkg::OccW-1:0]          o_rsp_occupancy
);
    import lwbc_pkg::*;

    localparam int SlotW = $clog2(SLOTS);
    localparam int CntW  = $clog2(SLOTS + 1);
    localparam int TagW  = (PAGE_ID_BITS < PageW) ? PAGE_ID_BITS : PageW;
    localparam int CmpW  = (CntW > CapW) ? CntW : CapW;
    localparam logic [CmpW-1:0]  SlotsCmp = CmpW'(SLOTS);
    localparam logic [SlotW-1:0] LastIdx  = SlotW'(SLOTS - 1);

    function automatic logic [SlotW-1:0] f_enc(input logic [SLOTS-1:0] oh);
        logic [SlotW-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (oh[i]) begin
                idx = idx | SlotW'(i);
            end
        end
        return idx;
    endfunction

    // Cache state.
    logic [TagW-1:0]  r_tag  [SLOTS];
    logic [SlotW-1:0] r_rank [SLOTS];
    logic [SlotW-1:0] n_rank [SLOTS];
    logic [SLOTS-1:0] r_vld, n_vld;
    logic [SLOTS-1:0] r_dty, n_dty;
    logic [CntW-1:0]  r_cnt, n_cnt;

    // Request and lookup results captured at acceptance.
    logic [OpW-1:0]   r_op;
    logic [TagW-1:0]  r_pid;
    logic [SLOTS-1:0] r_hit_oh, r_free_oh, r_vict_oh;
    logic             r_room;

    logic [SlotW-1:0] r_fidx;

    // Response register.
    logic                r_o_vld;
    logic                r_o_hit, n_o_hit;
    logic [SlotOutW-1:0] r_o_slot, n_o_slot;
    logic                r_o_fetch, n_o_fetch;
    logic                r_o_wb, n_o_wb;
    logic [PageW-1:0]    r_o_wbp, n_o_wbp;
    logic                r_o_last, n_o_last;
    logic [OccW-1:0]     r_o_occ, n_o_occ;

    logic [TagW-1:0]  pid_m;
    logic [SLOTS-1:0] hit_oh, free_oh, vict_oh, fl_oh, rd_oh, tgt_oh;
    logic [SlotW-1:0] cnt_m1, hit_rank, hit_idx, tgt_idx;
    logic [CmpW-1:0]  lim_ext, cap_eff;
    logic [TagW-1:0]  rd_tag;
    logic             rd_dty, hit_any, tag_we, load;

    // Lookup against the live state, registered at acceptance.
    assign pid_m   = i_req_page_id[TagW-1:0];
    assign cnt_m1  = SlotW'(r_cnt - CntW'(1));
    assign free_oh = ~r_vld & (r_vld + SLOTS'(1));
    assign lim_ext = CmpW'(i_cap_limit);
    assign cap_eff = (lim_ext == '0 || lim_ext > SlotsCmp) ? SlotsCmp : lim_ext;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_oh[i]  = r_vld[i] && (r_tag[i] == pid_m);
            // Ranks of valid slots are a permutation of 0..count-1.
            vict_oh[i] = r_vld[i] && (r_rank[i] == cnt_m1);
            fl_oh[i]   = (r_fidx == SlotW'(i));
        end
    end

    // One shared tag read port, steered by a one-hot select.
    assign rd_oh = i_cmd.fl_emit ? fl_oh : r_vict_oh;
    always_comb begin
        rd_tag   = '0;
        hit_rank = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (rd_oh[i]) begin
                rd_tag = rd_tag | r_tag[i];
            end
            if (r_hit_oh[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
        end
    end
    assign rd_dty = |(rd_oh & r_dty);

    assign hit_any = |r_hit_oh;
    assign hit_idx = f_enc(r_hit_oh);
    assign tgt_oh  = r_room ? r_free_oh : r_vict_oh;
    assign tgt_idx = f_enc(tgt_oh);

    assign o_stat.out_free = !r_o_vld || i_rsp_ready;
    assign o_stat.fl_hit   = |(fl_oh & r_vld & r_dty);
    assign o_stat.fl_end   = (r_fidx == LastIdx);

    always_comb begin
        n_vld     = r_vld;
        n_dty     = r_dty;
        n_rank    = r_rank;
        n_cnt     = r_cnt;
        tag_we    = 1'b0;
        n_o_hit   = 1'b0;
        n_o_slot  = '0;
        n_o_fetch = 1'b0;
        n_o_wb    = 1'b0;
        n_o_wbp   = '0;
        n_o_last  = 1'b1;
        load      = i_cmd.apply || i_cmd.fl_emit || i_cmd.fl_last;

        if (i_cmd.apply) begin
            case (r_op)
                OP_GET: begin
                    if (hit_any) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (r_hit_oh[i]) begin
                                n_rank[i] = '0;
                            end else if (r_vld[i] && r_rank[i] < hit_rank) begin
                                n_rank[i] = r_rank[i] + SlotW'(1);
                            end
                        end
                        n_o_hit  = 1'b1;
                        n_o_slot = SlotOutW'(hit_idx);
                    end else begin
                        tag_we = 1'b1;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (tgt_oh[i]) begin
                                n_rank[i] = '0;
                                n_vld[i]  = 1'b1;
                                n_dty[i]  = 1'b0;
                            end else if (r_vld[i]) begin
                                n_rank[i] = r_rank[i] + SlotW'(1);
                            end
                        end
                        if (r_room) begin
                            n_cnt = r_cnt + CntW'(1);
                        end
                        n_o_slot  = SlotOutW'(tgt_idx);
                        n_o_fetch = 1'b1;
                        n_o_wb    = !r_room && rd_dty;
                        n_o_wbp   = (!r_room && rd_dty) ? PageW'(rd_tag) : '0;
                    end
                end
                OP_MARK: begin
                    if (hit_any) begin
                        n_dty    = r_dty | r_hit_oh;
                        n_o_hit  = 1'b1;
                        n_o_slot = SlotOutW'(hit_idx);
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.fl_emit) begin
            n_dty    = r_dty & ~fl_oh;
            n_o_slot = SlotOutW'(r_fidx);
            n_o_wb   = 1'b1;
            n_o_wbp  = PageW'(rd_tag);
            n_o_last = 1'b0;
        end
        n_o_occ = OccW'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_dty   <= '0;
            r_cnt   <= '0;
            r_o_vld <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_vld  <= n_vld;
            r_dty  <= n_dty;
            r_cnt  <= n_cnt;
            r_rank <= n_rank;
            if (load) begin
                r_o_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (tag_we && tgt_oh[i]) begin
                r_tag[i] <= r_pid;
            end
        end
        if (i_cmd.capture) begin
            r_op      <= i_req_op;
            r_pid     <= pid_m;
            r_hit_oh  <= hit_oh;
            r_free_oh <= free_oh;
            r_vict_oh <= vict_oh;
            r_room    <= CmpW'(r_cnt) < cap_eff;
            r_fidx    <= '0;
        end else if (i_cmd.fl_adv) begin
            r_fidx    <= r_fidx + SlotW'(1);
        end
        if (load) begin
            r_o_hit   <= n_o_hit;
            r_o_slot  <= n_o_slot;
            r_o_fetch <= n_o_fetch;
            r_o_wb    <= n_o_wb;
            r_o_wbp   <= n_o_wbp;
            r_o_last  <= n_o_last;
            r_o_occ   <= n_o_occ;
        end
    end

    assign o_rsp_valid          = r_o_vld;
    assign o_rsp_hit            = r_o_hit;
    assign o_rsp_slot           = r_o_slot;
    assign o_rsp_fetch          = r_o_fetch;
    assign o_rsp_writeback      = r_o_wb;
    assign o_rsp_writeback_page = r_o_wbp;
    assign o_rsp_last           = r_o_last;
    assign o_rsp_occupancy      = r_o_occ;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == int'(r_cnt))
        else $error("resident count disagrees with valid bits");

    a_victim_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> $onehot(vict_oh))
        else $error("recency ranks do not single out one victim");

    a_tags_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit_oh))
        else $error("page resident in more than one slot");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_o_vld || i_rsp_ready))
        else $error("response register overwritten while held");

endmodule

`default_nettype wire

[hw/rtl/lwbc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lwbc_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    input  wire logic [lwbc_pkg::OpW-1:0]  i_req_op,
    input  wire lwbc_pkg::t_dp_stat        i_stat,
    output logic                           o_req_ready,
    output lwbc_pkg::t_ctl_cmd             o_cmd
);
    import lwbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_APPLY = 4'b0010,
        S_FLUSH = 4'b0100,
        S_FLAST = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Nothing is taken while reset is held.
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_req_op == OP_FLUSH) ? S_FLUSH : S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FLUSH: begin
                // Clean or empty slots are skipped; dirty ones wait for the output.
                if (i_stat.fl_hit) begin
                    o_cmd.fl_emit = i_stat.out_free;
                    o_cmd.fl_adv  = i_stat.out_free;
                end else begin
                    o_cmd.fl_adv = 1'b1;
                end
                if (o_cmd.fl_adv && i_stat.fl_end) begin
                    n_state = S_FLAST;
                end
            end
            S_FLAST: begin
                if (i_stat.out_free) begin
                    o_cmd.fl_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_req_ready)
        else $error("request taken while the previous one is in work");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the LRU write-back page cache. A behavioural mirror of the tag
// store, valid and dirty bits, recency ranks and resident count is kept here. Every accepted
// request is run through that mirror, which queues the response words the block must give.
// The checking process pops the oldest queued word for every word taken from the block and
// compares it with what the block actually produced.
module testbench;
    import lwbc_pkg::*;

    localparam int NumSlots    = 16;
    localparam int IdlePercent = 19;
    localparam int CycleLimit  = 500000;
    // The op encoding has one value that the package leaves unnamed; the block must answer
    // it with a single closing word and no change of state.
    localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                hit;
        logic [SlotOutW-1:0] slot;
        logic                fetch;
        logic                writeback;
        logic [PageW-1:0]    writeback_page;
        logic                last;
        logic [OccW-1:0]     occupancy;
    } t_rsp_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    lwbc_req_if req_bus ();
    lwbc_rsp_if rsp_bus ();

    lru_write_back_page_cache #(
        .SLOTS        (NumSlots),
        .PAGE_ID_BITS (PageW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the cache state. Ranks count up from zero for the most recent valid slot.
    logic [PageW-1:0] mirror_tag   [NumSlots];
    logic             mirror_valid [NumSlots];
    logic             mirror_dirty [NumSlots];
    int unsigned      mirror_rank  [NumSlots];
    int unsigned      mirror_count;
    logic [CapW-1:0]  mirror_cap;

    // Response words still owed by the block, oldest first.
    t_rsp_word pending_words[$];

    // While this is set neither side idles, giving a long stretch at full rate.
    logic steady_flow = 1'b0;

    int fault_count     = 0;
    int cycle_count     = 0;
    int requests_sent   = 0;
    int words_checked   = 0;
    int hit_count       = 0;
    int evict_count     = 0;
    int writeback_count = 0;
    int settings_used   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void record_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic int lookup_slot(input logic [PageW-1:0] page);
        for (int i = 0; i < NumSlots; i++) begin
            if (mirror_valid[i] && mirror_tag[i] == page) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Make slot s the most recent one; every other valid slot younger than bound ages by one.
    function automatic void promote_slot(input int s, input int unsigned bound);
        for (int i = 0; i < NumSlots; i++) begin
            if (i != s && mirror_valid[i] && mirror_rank[i] < bound) begin
                mirror_rank[i]++;
            end
        end
        mirror_rank[s] = 0;
    endfunction

    function automatic void owe_word(input logic hit, input int slot, input logic fetch,
                                     input logic wb, input logic [PageW-1:0] wb_page,
                                     input logic last);
        t_rsp_word w;
        w.hit            = hit;
        w.slot           = SlotOutW'(slot);
        w.fetch          = fetch;
        w.writeback      = wb;
        w.writeback_page = wb_page;
        w.last           = last;
        w.occupancy      = OccW'(mirror_count);
        pending_words.push_back(w);
        if (wb) begin
            writeback_count++;
        end
    endfunction

    // Apply one accepted request to the mirror and queue the words it must produce.
    function automatic void predict_cache_op(input logic [OpW-1:0] op,
                                             input logic [PageW-1:0] page);
        int               s;
        int unsigned      cap;
        int unsigned      worst;
        logic             wb;
        logic [PageW-1:0] wb_page;

        case (op)
            OP_GET: begin
                // A capacity of zero, or any above the slot count, means every slot.
                cap = (mirror_cap == 0 || mirror_cap > NumSlots) ? NumSlots : mirror_cap;
                s = lookup_slot(page);
                if (s >= 0) begin
                    hit_count++;
                    promote_slot(s, mirror_rank[s]);
                    owe_word(1'b1, s, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    wb      = 1'b0;
                    wb_page = '0;
                    if (mirror_count < cap) begin
                        // Below capacity the lowest free slot takes the page.
                        s = 0;
                        while (mirror_valid[s]) begin
                            s++;
                        end
                        mirror_count++;
                    end else begin
                        // Otherwise the oldest page goes, even when capacity has been
                        // lowered below the present occupancy: exactly one page leaves.
                        worst = 0;
                        s     = 0;
                        for (int i = 0; i < NumSlots; i++) begin
                            if (mirror_valid[i] && mirror_rank[i] >= worst) begin
                                worst = mirror_rank[i];
                                s     = i;
                            end
                        end
                        if (mirror_dirty[s]) begin
                            wb      = 1'b1;
                            wb_page = mirror_tag[s];
                        end
                        mirror_valid[s] = 1'b0;
                        evict_count++;
                    end
                    mirror_tag[s]   = page;
                    mirror_dirty[s] = 1'b0;
                    promote_slot(s, 32'hFFFF_FFFF);
                    mirror_valid[s] = 1'b1;
                    owe_word(1'b0, s, 1'b1, wb, wb_page, 1'b1);
                end
            end
            OP_MARK: begin
                s = lookup_slot(page);
                if (s >= 0) begin
                    mirror_dirty[s] = 1'b1;
                    owe_word(1'b1, s, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    // Marking a page that is not resident changes nothing.
                    owe_word(1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
                end
            end
            OP_FLUSH: begin
                for (int i = 0; i < NumSlots; i++) begin
                    if (mirror_valid[i] && mirror_dirty[i]) begin
                        mirror_dirty[i] = 1'b0;
                        owe_word(1'b0, i, 1'b0, 1'b1, mirror_tag[i], 1'b0);
                    end
                end
                owe_word(1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
            end
            default: begin
                owe_word(1'b0, 0, 1'b0, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    // Offer one request word, idling now and then first, and hold it until it is taken.
    // On return the clock edge of acceptance has just passed and valid is still high.
    task automatic send_request(input logic [OpW-1:0] op, input logic [PageW-1:0] page);
        if (!steady_flow && $urandom_range(99) < IdlePercent) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 45);
        end
        req_bus.valid   <= 1'b1;
        req_bus.op      <= op;
        req_bus.page_id <= page;
        do @(posedge i_clk); while (!req_bus.ready);
        predict_cache_op(op, page);
        requests_sent++;
    endtask

    // Stop offering requests and wait until every owed word has been taken.
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the capacity register through a setup and an access phase, then read it back.
    // Only called with the block idle.
    task automatic write_capacity(input logic [DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(REG_CAP_LIMIT) << RegIdxBit;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror_cap = value[CapW-1:0];
        settings_used++;

        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CapW-1:0] !== mirror_cap) begin
            record_fault($sformatf("capacity read back %0d, written %0d",
                                   prdata[CapW-1:0], mirror_cap));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fill a few slots with the extreme page ids, hit one, mark pages dirty (one of them not
    // resident), flush twice so that the second flush finds nothing dirty, and send the
    // unused op code.
    task automatic test_fill_and_hit();
        send_request(OP_GET,   32'h0000_0000);
        send_request(OP_GET,   32'hFFFF_FFFF);
        send_request(OP_GET,   32'h5555_5555);
        send_request(OP_GET,   32'hAAAA_AAAA);
        send_request(OP_GET,   32'h0000_0000);
        send_request(OP_MARK,  32'hFFFF_FFFF);
        send_request(OP_MARK,  32'hAAAA_AAAA);
        send_request(OP_MARK,  32'h1234_5678);
        send_request(OP_FLUSH, 32'hFFFF_FFFF);
        send_request(OP_FLUSH, 32'h0000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    // Lower the capacity below the present occupancy, so that misses replace the oldest page
    // one for one, including a dirty one that must be written back. Then try a capacity
    // beyond the slot count and the smallest capacity of one.
    task automatic test_capacity_shrink();
        write_capacity(2);
        send_request(OP_MARK, 32'h5555_5555);
        send_request(OP_GET,  32'h0000_0001);
        send_request(OP_GET,  32'h0000_0002);
        send_request(OP_GET,  32'h0000_0001);
        wait_for_results();
        write_capacity(31);
        send_request(OP_GET,  32'h0000_0003);
        wait_for_results();
        write_capacity(1);
        send_request(OP_GET,  32'h0000_0004);
        send_request(OP_GET,  32'h0000_0004);
        wait_for_results();
    endtask

    // Random traffic under a series of capacity settings. Page ids come mostly from a small
    // pool per phase so that hits, dirty evictions and flush writebacks happen often; the
    // rest are fresh ids. Half-way through each phase the sender waits for every owed word.
    task automatic test_random_traffic();
        logic [DataW-1:0] caps [7];
        logic [PageW-1:0] pool [24];
        int               pool_size;
        int               pick;
        logic [PageW-1:0] page;

        caps = '{0, 16, 1, 31, 5, 0, 0};
        caps[5] = DataW'($urandom_range(15, 2));
        for (int p = 0; p < 7; p++) begin
            write_capacity(caps[p]);
            steady_flow = (p == 2);
            pool_size = (caps[p] == 0 || caps[p] > NumSlots) ? 22 : int'(caps[p]) + 4;
            for (int i = 0; i < pool_size; i++) begin
                pool[i] = $urandom();
            end
            for (int n = 0; n < 30; n++) begin
                page = ($urandom_range(99) < 88) ? pool[$urandom_range(pool_size - 1)]
                                                 : $urandom();
                pick = $urandom_range(99);
                if (pick < 58) begin
                    send_request(OP_GET, page);
                end else if (pick < 84) begin
                    send_request(OP_MARK, page);
                end else if (pick < 97) begin
                    send_request(OP_FLUSH, $urandom());
                end else begin
                    send_request(OP_UNUSED, $urandom());
                end
                if (n == 15) begin
                    wait_for_results();
                end
            end
            wait_for_results();
        end
        steady_flow = 1'b0;
    endtask

    // Checking process: every word taken from the block is compared with the oldest owed
    // word. The receiver's ready is redrawn at every edge unless the flow is steady.
    always @(posedge i_clk) begin
        t_rsp_word seen;
        t_rsp_word owed;

        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            seen.hit            = rsp_bus.hit;
            seen.slot           = rsp_bus.slot;
            seen.fetch          = rsp_bus.fetch;
            seen.writeback      = rsp_bus.writeback;
            seen.writeback_page = rsp_bus.writeback_page;
            seen.last           = rsp_bus.last;
            seen.occupancy      = rsp_bus.occupancy;
            if (pending_words.size() == 0) begin
                record_fault($sformatf("word with nothing owed: hit %0b slot %0d fetch %0b wb %0b page %h last %0b occ %0d",
                                       seen.hit, seen.slot, seen.fetch, seen.writeback,
                                       seen.writeback_page, seen.last, seen.occupancy));
            end else begin
                owed = pending_words.pop_front();
                words_checked++;
                if (seen !== owed) begin
                    record_fault($sformatf({"expected hit %0b slot %0d fetch %0b wb %0b ",
                                            "page %h last %0b occ %0d, got hit %0b slot %0d ",
                                            "fetch %0b wb %0b page %h last %0b occ %0d"},
                                           owed.hit, owed.slot, owed.fetch, owed.writeback,
                                           owed.writeback_page, owed.last, owed.occupancy,
                                           seen.hit, seen.slot, seen.fetch, seen.writeback,
                                           seen.writeback_page, seen.last, seen.occupancy));
                end
            end
        end
        rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IdlePercent);
    end

    // Watchdog: a run far beyond the slowest correct one is taken as a hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_bus.valid   = 1'b0;
        req_bus.op      = OP_GET;
        req_bus.page_id = '0;
        rsp_bus.ready   = 1'b0;
        for (int i = 0; i < NumSlots; i++) begin
            mirror_tag[i]   = '0;
            mirror_valid[i] = 1'b0;
            mirror_dirty[i] = 1'b0;
            mirror_rank[i]  = 0;
        end
        mirror_count = 0;
        mirror_cap   = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_capacity_shrink();
        test_random_traffic();

        // Let a few more edges pass so that any stray extra word would still be caught.
        wait_for_results();
        repeat (2 * NumSlots) @(posedge i_clk);

        $display("Sent %0d requests under %0d capacity writes: %0d hits, %0d evictions.",
                 requests_sent, settings_used, hit_count, evict_count);
        $display("Checked %0d response words, %0d of them writebacks; %0d mismatches.",
                 words_checked, writeback_count, fault_count);
        if (fault_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lwbc_pkg.sv
hw/rtl/lwbc_req_if.sv
hw/rtl/lwbc_rsp_if.sv
hw/rtl/lwbc_dp.sv
hw/rtl/lwbc_ctrl.sv
hw/rtl/lru_write_back_page_cache.sv
tb/sv/testbench.sv
